### src/usbhc_pkg.sv
// shared types and constants for the usb host controller register files
`default_nettype none

package usbhc_pkg;

  localparam int UHCI_SPACE_BYTES_DEF = 32;
  localparam int EHCI_SPACE_BYTES_DEF = 128;
  localparam int NUM_UHCI_DEF         = 4;

  localparam logic [7:0]  UHCI_USBCMD   = 8'h00;
  localparam logic [7:0]  UHCI_USBINTR  = 8'h04;
  localparam logic [7:0]  UHCI_FRNUM_LO = 8'h06;
  localparam logic [7:0]  UHCI_FRNUM_HI = 8'h07;
  localparam logic [7:0]  UHCI_PORTSC1  = 8'h10;
  localparam logic [7:0]  UHCI_PORTSC2  = 8'h12;
  localparam logic [31:0] UHCI_RWC_MASK = 32'h000f000c;
  localparam logic [8:0]  EHCI_RWC_LO   = 9'h044;
  localparam logic [8:0]  EHCI_RWC_HI   = 9'h064;
  localparam logic [7:0]  PORT_STS_BIT  = 8'h80;
  localparam logic [7:0]  HCRESET_BIT   = 8'h02;
  localparam logic [2:0]  MAX_BYTES     = 3'd4;
  localparam logic [2:0]  EHCI_SEL      = 3'd4;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PORT,
    ST_ACC,
    ST_HRST,
    ST_TICK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  controller;
    logic [7:0]  byte_offset;
    logic [2:0]  byte_count;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [3:0]  irq_request;
  } out_item_t;

endpackage

`default_nettype wire

### src/usb_host_controller_regs.sv
// One item in flight at a time. A UHCI read first sets the port status bits in PORTSC1/2,
// a UHCI write ends by clearing HCRESET in USBCMD, and a tick walks every UHCI controller.
// Every byte is a read, then a write-back (or capture, for a read) on its single-port byte memory.
// A finished result waits in the output register while the next item is taken.
// Synchronous reset starts a clearing pass over max(NUM_UHCI*UHCI_SPACE_BYTES,
// EHCI_SPACE_BYTES) addresses (128 by default) that zeroes both memories; no item before it ends.
`default_nettype none

module usb_host_controller_regs #(
  parameter int UHCI_SPACE_BYTES = usbhc_pkg::UHCI_SPACE_BYTES_DEF,
  parameter int EHCI_SPACE_BYTES = usbhc_pkg::EHCI_SPACE_BYTES_DEF,
  parameter int NUM_UHCI         = usbhc_pkg::NUM_UHCI_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire usbhc_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire                       out_stall,
  output usbhc_pkg::out_item_t      out_data
);

  localparam int U_DEPTH = NUM_UHCI * UHCI_SPACE_BYTES;
  localparam int UA_W    = $clog2(U_DEPTH);
  localparam int EA_W    = $clog2(EHCI_SPACE_BYTES);
  localparam int CLR_LEN = (U_DEPTH > EHCI_SPACE_BYTES) ? U_DEPTH : EHCI_SPACE_BYTES;
  localparam int CLR_W   = $clog2(CLR_LEN + 1);
  localparam int TK_W    = (NUM_UHCI > 1) ? $clog2(NUM_UHCI) : 1;

  logic [7:0] u_mem [U_DEPTH];
  logic [7:0] e_mem [EHCI_SPACE_BYTES];

  usbhc_pkg::state_t state_r, state_nxt;
  logic [CLR_W-1:0] clr_r, clr_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [2:0]       ctl_r, ctl_nxt;
  logic [7:0]       base_r, base_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [31:0]      wd_r, wd_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic             ph_r, ph_nxt;
  logic [31:0]      rd_r, rd_nxt;
  logic [3:0]       irq_r, irq_nxt;
  logic [TK_W-1:0]  tk_r, tk_nxt;
  logic [1:0]       tb_r, tb_nxt;
  logic             run_r, run_nxt;
  logic             ie_r, ie_nxt;
  logic             carry_r, carry_nxt;
  logic             out_valid_r, out_valid_nxt;
  usbhc_pkg::out_item_t out_data_r, out_data_nxt;

  logic [7:0]      u_rdata_r;
  logic [7:0]      e_rdata_r;
  logic [UA_W-1:0] u_addr;
  logic [EA_W-1:0] e_addr;
  logic            u_we, e_we;
  logic [7:0]      m_wdata;

  logic [8:0]  a_byte;
  logic [2:0]  u_ctl_sel;
  logic [9:0]  u_full;
  logic        is_uhci;
  logic        u_hit, e_hit;
  logic        rwc;
  logic [7:0]  rbyte;
  logic [7:0]  wb;
  logic        in_xfer;
  logic        out_load;

  assign in_stall  = (state_r != usbhc_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign is_uhci   = (ctl_r < 3'(NUM_UHCI));
  assign out_load  = (state_r == usbhc_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  // byte address of the current access
  always_comb begin
    a_byte    = 9'(base_r) + 9'(idx_r);
    u_ctl_sel = ctl_r;
    case (state_r)
      usbhc_pkg::ST_PORT: begin
        a_byte = idx_r[0] ? 9'(usbhc_pkg::UHCI_PORTSC2) : 9'(usbhc_pkg::UHCI_PORTSC1);
      end
      usbhc_pkg::ST_HRST: begin
        a_byte = 9'(usbhc_pkg::UHCI_USBCMD);
      end
      usbhc_pkg::ST_TICK: begin
        u_ctl_sel = 3'(tk_r);
        case (tb_r)
          2'd0:    a_byte = 9'(usbhc_pkg::UHCI_USBCMD);
          2'd1:    a_byte = 9'(usbhc_pkg::UHCI_USBINTR);
          2'd2:    a_byte = 9'(usbhc_pkg::UHCI_FRNUM_LO);
          default: a_byte = 9'(usbhc_pkg::UHCI_FRNUM_HI);
        endcase
      end
      default: begin
        a_byte = 9'(base_r) + 9'(idx_r);
      end
    endcase
  end

  always_comb begin
    u_full = 10'(u_ctl_sel) * 10'(UHCI_SPACE_BYTES) + 10'(a_byte);
    u_hit  = 1'b0;
    e_hit  = 1'b0;
    case (state_r)
      usbhc_pkg::ST_PORT, usbhc_pkg::ST_HRST, usbhc_pkg::ST_TICK: begin
        u_hit = 1'b1;
      end
      usbhc_pkg::ST_ACC: begin
        u_hit = is_uhci && (a_byte < 9'(UHCI_SPACE_BYTES));
        e_hit = (ctl_r >= usbhc_pkg::EHCI_SEL) && (a_byte < 9'(EHCI_SPACE_BYTES));
      end
      default: begin
        u_hit = 1'b0;
        e_hit = 1'b0;
      end
    endcase
    rbyte = u_hit ? u_rdata_r : (e_hit ? e_rdata_r : 8'h00);
    wb    = wd_r[{idx_r[1:0], 3'b000} +: 8];
    rwc   = u_hit ? usbhc_pkg::UHCI_RWC_MASK[a_byte[4:0]]
                  : ((a_byte > usbhc_pkg::EHCI_RWC_LO) && (a_byte < usbhc_pkg::EHCI_RWC_HI));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      usbhc_pkg::ST_CLEAR: begin
        if (clr_r == CLR_W'(CLR_LEN - 1)) state_nxt = usbhc_pkg::ST_IDLE;
      end
      usbhc_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_data.opcode)
            usbhc_pkg::OP_READ: begin
              state_nxt = (in_data.controller < 3'(NUM_UHCI)) ? usbhc_pkg::ST_PORT
                                                                : usbhc_pkg::ST_ACC;
            end
            usbhc_pkg::OP_WRITE: state_nxt = usbhc_pkg::ST_ACC;
            usbhc_pkg::OP_TICK:  state_nxt = usbhc_pkg::ST_TICK;
            default:             state_nxt = usbhc_pkg::ST_DONE;
          endcase
        end
      end
      usbhc_pkg::ST_PORT: begin
        if (ph_r && idx_r[0]) state_nxt = usbhc_pkg::ST_ACC;
      end
      usbhc_pkg::ST_ACC: begin
        if (idx_r == cnt_r) begin
          state_nxt = (op_r == usbhc_pkg::OP_WRITE && is_uhci) ? usbhc_pkg::ST_HRST
                                                                : usbhc_pkg::ST_DONE;
        end
      end
      usbhc_pkg::ST_HRST: begin
        if (ph_r) state_nxt = usbhc_pkg::ST_DONE;
      end
      usbhc_pkg::ST_TICK: begin
        if (ph_r && tb_r == 2'd3 && tk_r == TK_W'(NUM_UHCI - 1)) state_nxt = usbhc_pkg::ST_DONE;
      end
      usbhc_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = usbhc_pkg::ST_IDLE;
      end
      default: state_nxt = usbhc_pkg::ST_CLEAR;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    ctl_nxt       = ctl_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    wd_nxt        = wd_r;
    idx_nxt       = idx_r;
    ph_nxt        = ph_r;
    rd_nxt        = rd_r;
    irq_nxt       = irq_r;
    tk_nxt        = tk_r;
    tb_nxt        = tb_r;
    run_nxt       = run_r;
    ie_nxt        = ie_r;
    carry_nxt     = carry_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    u_addr        = u_full[UA_W-1:0];
    e_addr        = a_byte[EA_W-1:0];
    u_we          = 1'b0;
    e_we          = 1'b0;
    m_wdata       = 8'h00;
    case (state_r)
      usbhc_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        u_addr  = clr_r[UA_W-1:0];
        e_addr  = clr_r[EA_W-1:0];
        u_we    = (clr_r < CLR_W'(U_DEPTH));
        e_we    = (clr_r < CLR_W'(EHCI_SPACE_BYTES));
      end
      usbhc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          op_nxt   = in_data.opcode;
          ctl_nxt  = in_data.controller;
          base_nxt = in_data.byte_offset;
          cnt_nxt  = (in_data.byte_count > usbhc_pkg::MAX_BYTES) ? usbhc_pkg::MAX_BYTES
                                                                  : in_data.byte_count;
          wd_nxt   = in_data.write_data;
          idx_nxt  = 3'd0;
          ph_nxt   = 1'b0;
          rd_nxt   = 32'h0;
          irq_nxt  = 4'h0;
          tk_nxt   = '0;
          tb_nxt   = 2'd0;
        end
      end
      usbhc_pkg::ST_PORT: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          u_we    = 1'b1;
          m_wdata = rbyte | usbhc_pkg::PORT_STS_BIT;
          idx_nxt = idx_r[0] ? 3'd0 : 3'd1;
        end
      end
      usbhc_pkg::ST_ACC: begin
        if (idx_r != cnt_r) begin
          ph_nxt = !ph_r;
          if (ph_r) begin
            idx_nxt = idx_r + 3'd1;
            if (op_r == usbhc_pkg::OP_WRITE) begin
              u_we    = u_hit;
              e_we    = e_hit;
              m_wdata = rwc ? (rbyte & ~wb) : wb;
            end else begin
              rd_nxt = rd_r | (32'(rbyte) << {idx_r[1:0], 3'b000});
            end
          end
        end
      end
      usbhc_pkg::ST_HRST: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          u_we    = 1'b1;
          m_wdata = rbyte & ~usbhc_pkg::HCRESET_BIT;
        end
      end
      usbhc_pkg::ST_TICK: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          tb_nxt = tb_r + 2'd1;
          case (tb_r)
            2'd0: run_nxt = rbyte[0];
            2'd1: ie_nxt  = rbyte[2];
            2'd2: begin
              u_we      = run_r;
              m_wdata   = rbyte + 8'd1;
              carry_nxt = (rbyte == 8'hff);
            end
            default: begin
              u_we    = run_r;
              m_wdata = rbyte + {7'd0, carry_r};
              if (run_r && ie_r) irq_nxt = irq_r | (4'd1 << tk_r);
              tk_nxt  = tk_r + 1'b1;
            end
          endcase
        end
      end
      usbhc_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.read_data   = rd_r;
          out_data_nxt.irq_request = irq_r;
        end
      end
      default: begin
        u_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= usbhc_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    ctl_r      <= ctl_nxt;
    base_r     <= base_nxt;
    cnt_r      <= cnt_nxt;
    wd_r       <= wd_nxt;
    idx_r      <= idx_nxt;
    ph_r       <= ph_nxt;
    rd_r       <= rd_nxt;
    irq_r      <= irq_nxt;
    tk_r       <= tk_nxt;
    tb_r       <= tb_nxt;
    run_r      <= run_nxt;
    ie_r       <= ie_nxt;
    carry_r    <= carry_nxt;
    out_data_r <= out_data_nxt;
  end

  // byte memories, read every cycle at the current address
  always_ff @(posedge clk) begin
    if (u_we) u_mem[u_addr] <= m_wdata;
    u_rdata_r <= u_mem[u_addr];
  end

  always_ff @(posedge clk) begin
    if (e_we) e_mem[e_addr] <= m_wdata;
    e_rdata_r <= e_mem[e_addr];
  end

`ifndef ASSERT_OFF
  a_irq_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == usbhc_pkg::ST_DONE && op_r != usbhc_pkg::OP_TICK) |-> (irq_r == 4'h0))
    else $error("irq raised by a non-tick item");

  a_rd_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == usbhc_pkg::ST_DONE && op_r != usbhc_pkg::OP_READ) |-> (rd_r == 32'h0))
    else $error("read data set by a non-read item");

  a_wb_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ((u_we || e_we) && state_r != usbhc_pkg::ST_CLEAR) |-> ph_r)
    else $error("memory write outside the write-back phase");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != usbhc_pkg::ST_IDLE))
    else $error("transfer taken but sequencer stayed idle");
`endif

endmodule

`default_nettype wire

### tb/tb_usb_host_controller_regs.sv
// testbench for the usb host controller register files: directed table, then random traffic
module tb_usb_host_controller_regs;

  localparam int UHCI_BYTES   = usbhc_pkg::UHCI_SPACE_BYTES_DEF;
  localparam int EHCI_BYTES   = usbhc_pkg::EHCI_SPACE_BYTES_DEF;
  localparam int UHCI_COUNT   = usbhc_pkg::NUM_UHCI_DEF;
  localparam int RUN_BIT      = 0;
  localparam int IRQ_EN_BIT   = 2;
  localparam int PHASE_ITEMS  = 175;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    usbhc_pkg::in_item_t item;
    bit                  typed;
    logic [31:0]         read_data;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  usbhc_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  usbhc_pkg::out_item_t out_data;

  logic [7:0] uhci_mem [UHCI_COUNT][UHCI_BYTES];
  logic [7:0] ehci_mem [EHCI_BYTES];

  usbhc_pkg::out_item_t pending_results [$];
  dir_row_t             directed_rows [$];
  int                   mismatch_count = 0;
  int                   cycle_count = 0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  bit                   hold_request = 0;
  int                   hold_left = 0;

  usb_host_controller_regs i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // byte-level model of all register spaces; returns the result of one transfer
  function automatic usbhc_pkg::out_item_t regfile_access(usbhc_pkg::in_item_t it);
    usbhc_pkg::out_item_t res;
    int unsigned ctl, cnt, addr, i, u;
    logic [7:0]  b;
    logic [15:0] frame;
    bit          is_uhci, is_ehci;
    res = '0;
    ctl = 32'(it.controller);
    cnt = (it.byte_count > usbhc_pkg::MAX_BYTES) ? 32'(usbhc_pkg::MAX_BYTES)
                                                 : 32'(it.byte_count);
    is_uhci = ctl < UHCI_COUNT;
    is_ehci = ctl >= 32'(usbhc_pkg::EHCI_SEL);
    case (usbhc_pkg::op_t'(it.opcode))
      usbhc_pkg::OP_READ: begin
        if (is_uhci) begin
          uhci_mem[ctl][usbhc_pkg::UHCI_PORTSC1] |= usbhc_pkg::PORT_STS_BIT;
          uhci_mem[ctl][usbhc_pkg::UHCI_PORTSC2] |= usbhc_pkg::PORT_STS_BIT;
        end
        for (i = 0; i < cnt; i++) begin
          addr = 32'(it.byte_offset) + i;
          b = 8'h00;
          if (is_uhci && addr < UHCI_BYTES) b = uhci_mem[ctl][addr];
          else if (is_ehci && addr < EHCI_BYTES) b = ehci_mem[addr];
          res.read_data[8*i +: 8] = b;
        end
      end
      usbhc_pkg::OP_WRITE: begin
        for (i = 0; i < cnt; i++) begin
          addr = 32'(it.byte_offset) + i;
          b = it.write_data[8*i +: 8];
          if (is_uhci && addr < UHCI_BYTES) begin
            if (usbhc_pkg::UHCI_RWC_MASK[addr]) uhci_mem[ctl][addr] &= ~b;
            else uhci_mem[ctl][addr] = b;
          end else if (is_ehci && addr < EHCI_BYTES) begin
            if (addr > 32'(usbhc_pkg::EHCI_RWC_LO) && addr < 32'(usbhc_pkg::EHCI_RWC_HI))
              ehci_mem[addr] &= ~b;
            else ehci_mem[addr] = b;
          end
        end
        if (is_uhci) uhci_mem[ctl][usbhc_pkg::UHCI_USBCMD] &= ~usbhc_pkg::HCRESET_BIT;
      end
      usbhc_pkg::OP_TICK: begin
        for (u = 0; u < UHCI_COUNT; u++) begin
          if (uhci_mem[u][usbhc_pkg::UHCI_USBCMD][RUN_BIT]) begin
            frame = {uhci_mem[u][usbhc_pkg::UHCI_FRNUM_HI],
                     uhci_mem[u][usbhc_pkg::UHCI_FRNUM_LO]} + 16'd1;
            uhci_mem[u][usbhc_pkg::UHCI_FRNUM_LO] = frame[7:0];
            uhci_mem[u][usbhc_pkg::UHCI_FRNUM_HI] = frame[15:8];
            if (uhci_mem[u][usbhc_pkg::UHCI_USBINTR][IRQ_EN_BIT]) res.irq_request[u] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_row(usbhc_pkg::op_t op, int ctl, int off, int cnt,
                                  logic [31:0] wd, bit typed, logic [31:0] rd);
    dir_row_t r;
    r.item = '{opcode: op, controller: 3'(ctl), byte_offset: 8'(off), byte_count: 3'(cnt),
               write_data: wd};
    r.typed = typed;
    r.read_data = rd;
    directed_rows.push_back(r);
  endfunction

  function automatic usbhc_pkg::in_item_t random_access();
    usbhc_pkg::in_item_t it;
    int                  r;
    r = $urandom_range(99);
    if (r < 40) it.opcode = usbhc_pkg::OP_READ;
    else if (r < 78) it.opcode = usbhc_pkg::OP_WRITE;
    else if (r < 95) it.opcode = usbhc_pkg::OP_TICK;
    else it.opcode = usbhc_pkg::OP_NOP;
    it.controller = 3'($urandom_range(7));
    r = $urandom_range(99);
    // most accesses land on the interesting registers or inside the space
    if (r < 30) begin
      if (it.controller >= usbhc_pkg::EHCI_SEL) begin
        case ($urandom_range(2))
          0: it.byte_offset = 8'(usbhc_pkg::EHCI_RWC_LO);
          1: it.byte_offset = 8'h60;
          default: it.byte_offset = 8'h7e;
        endcase
      end else begin
        case ($urandom_range(4))
          0: it.byte_offset = usbhc_pkg::UHCI_USBCMD;
          1: it.byte_offset = usbhc_pkg::UHCI_USBINTR;
          2: it.byte_offset = usbhc_pkg::UHCI_FRNUM_LO;
          3: it.byte_offset = usbhc_pkg::UHCI_PORTSC1;
          default: it.byte_offset = usbhc_pkg::UHCI_PORTSC2;
        endcase
      end
    end else if (r < 80) begin
      it.byte_offset = (it.controller >= usbhc_pkg::EHCI_SEL)
                       ? 8'($urandom_range(EHCI_BYTES - 1))
                       : 8'($urandom_range(UHCI_BYTES - 1));
    end else begin
      it.byte_offset = 8'($urandom_range(255));
    end
    it.byte_count = ($urandom_range(99) < 85) ? 3'($urandom_range(1, 4))
                                              : 3'($urandom_range(7));
    it.write_data = $urandom();
    return it;
  endfunction

  task automatic offer(input usbhc_pkg::in_item_t it, input bit typed,
                       input logic [31:0] typed_rd);
    usbhc_pkg::out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = regfile_access(it);
    if (typed) predicted = '{read_data: typed_rd, irq_request: 4'h0};
    pending_results.push_back(predicted);
  endtask

  function automatic void report_mismatch(string what, usbhc_pkg::out_item_t exp_r,
                                          usbhc_pkg::out_item_t got_r);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch (%s): expected read_data %h irq %h, got read_data %h irq %h",
               what, exp_r.read_data, exp_r.irq_request, got_r.read_data, got_r.irq_request);
  endfunction

  always @(posedge clk) begin
    usbhc_pkg::out_item_t exp_r;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("no transfer outstanding", '0, out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.read_data !== exp_r.read_data ||
            out_data.irq_request !== exp_r.irq_request)
          report_mismatch("field", exp_r, out_data);
      end
    end
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 0;
    end
    // long hold-off lets the block fill up and back-pressure the sender
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    // after reset: port bits appear on the first read, everything else zero
    add_row(usbhc_pkg::OP_READ,  0, 8'h00, 4, 32'h0,        1, 32'h0);
    add_row(usbhc_pkg::OP_READ,  0, 8'h10, 4, 32'h0,        1, 32'h0080_0080);
    add_row(usbhc_pkg::OP_READ,  4, 8'h7e, 4, 32'h0,        1, 32'h0);
    add_row(usbhc_pkg::OP_READ,  3, 8'hff, 7, 32'hffff_ffff, 1, 32'h0);
    add_row(usbhc_pkg::OP_READ,  1, 8'h10, 0, 32'h0,        1, 32'h0);
    add_row(usbhc_pkg::OP_READ,  1, 8'h10, 4, 32'h0,        0, 32'h0);
    // host reset bit drops right after the write
    add_row(usbhc_pkg::OP_WRITE, 0, 8'h00, 4, 32'hffff_ffff, 1, 32'h0);
    add_row(usbhc_pkg::OP_READ,  0, 8'h00, 4, 32'h0,        0, 32'h0);
    add_row(usbhc_pkg::OP_WRITE, 0, 8'h04, 4, 32'h0000_ff04, 1, 32'h0);
    add_row(usbhc_pkg::OP_TICK,  0, 8'h00, 1, 32'h0,        0, 32'h0);
    // frame number wraps
    add_row(usbhc_pkg::OP_WRITE, 0, 8'h06, 2, 32'h0000_ffff, 1, 32'h0);
    add_row(usbhc_pkg::OP_TICK,  7, 8'hff, 7, 32'hffff_ffff, 0, 32'h0);
    add_row(usbhc_pkg::OP_READ,  0, 8'h04, 4, 32'h0,        0, 32'h0);
    add_row(usbhc_pkg::OP_WRITE, 0, 8'h10, 4, 32'hffff_ffff, 1, 32'h0);
    add_row(usbhc_pkg::OP_READ,  0, 8'h10, 4, 32'h0,        0, 32'h0);
    add_row(usbhc_pkg::OP_WRITE, 7, 8'h40, 4, 32'hffff_ffff, 1, 32'h0);
    add_row(usbhc_pkg::OP_WRITE, 5, 8'h44, 4, 32'ha5a5_a5a5, 1, 32'h0);
    add_row(usbhc_pkg::OP_READ,  6, 8'h42, 4, 32'h0,        0, 32'h0);
    add_row(usbhc_pkg::OP_WRITE, 4, 8'h62, 4, 32'hffff_ffff, 1, 32'h0);
    add_row(usbhc_pkg::OP_READ,  4, 8'h62, 4, 32'h0,        0, 32'h0);
    add_row(usbhc_pkg::OP_WRITE, 2, 8'h1e, 4, 32'h1234_5678, 1, 32'h0);
    add_row(usbhc_pkg::OP_READ,  2, 8'h1e, 4, 32'h0,        0, 32'h0);
    add_row(usbhc_pkg::OP_NOP,   0, 8'h00, 4, 32'hffff_ffff, 1, 32'h0);
    add_row(usbhc_pkg::OP_READ,  4, 8'h7f, 3, 32'h0,        0, 32'h0);
    add_row(usbhc_pkg::OP_TICK,  0, 8'h00, 1, 32'h0,        0, 32'h0);

    foreach (uhci_mem[c, a]) uhci_mem[c][a] = 8'h00;
    foreach (ehci_mem[a]) ehci_mem[a] = 8'h00;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      offer(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].read_data);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_request = 1; end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      repeat (PHASE_ITEMS) offer(random_access(), 0, 32'h0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
